### rtl/lr_pkg.sv
// shared types for the line rasterizer
`timescale 1ns / 1ps

package lr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } lr_state_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } lr_mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lr_div_stat_t;

endpackage

### rtl/lr_cmd_if.sv
// command channel: load or step word
`timescale 1ns / 1ps

interface lr_cmd_if #(
  parameter int W = 10
);
  logic         valid;
  logic         ready;
  logic         mode;
  logic [W-1:0] first_x;
  logic [W-1:0] first_y;
  logic [W-1:0] second_x;
  logic [W-1:0] second_y;

  modport source (
    output valid, mode, first_x, first_y, second_x, second_y,
    input  ready
  );
  modport sink (
    input  valid, mode, first_x, first_y, second_x, second_y,
    output ready
  );
endinterface

### rtl/lr_pixel_if.sv
// pixel channel: one plotted pixel per word
`timescale 1ns / 1ps

interface lr_pixel_if #(
  parameter int W = 10
);
  logic         valid;
  logic         ready;
  logic [W-1:0] pixel_x;
  logic [W-1:0] pixel_y;
  logic         last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, last_pixel,
    output ready
  );
endinterface

### rtl/lr_div.sv
// iterative unsigned divider, two quotient bits per cycle
`timescale 1ns / 1ps

module lr_div #(
  parameter int NUM_BITS = 20,
  parameter int DEN_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]  den,
  output logic [NUM_BITS-1:0]  quot,
  output logic [DEN_BITS-1:0]  rem,
  output lr_pkg::lr_div_stat_t stat
);

  localparam int STEPS = (NUM_BITS + 1) / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [NUM_BITS-1:0] q_reg;
  logic [DEN_BITS-1:0] r_reg;
  logic [DEN_BITS-1:0] den_reg;
  logic [CW-1:0]       count;
  logic                busy;
  logic                done;

  logic [DEN_BITS:0]   t1, t2, d1, d2;
  logic                ge1, ge2;
  logic [DEN_BITS-1:0] r1;
  logic [NUM_BITS-1:0] q1;
  logic [DEN_BITS-1:0] r_next;
  logic [NUM_BITS-1:0] q_next;

  // two dependent restoring steps
  always_comb begin
    t1     = {r_reg, q_reg[NUM_BITS-1]};
    ge1    = t1 >= {1'b0, den_reg};
    d1     = t1 - {1'b0, den_reg};
    r1     = ge1 ? d1[DEN_BITS-1:0] : t1[DEN_BITS-1:0];
    q1     = {q_reg[NUM_BITS-2:0], ge1};
    t2     = {r1, q1[NUM_BITS-1]};
    ge2    = t2 >= {1'b0, den_reg};
    d2     = t2 - {1'b0, den_reg};
    r_next = ge2 ? d2[DEN_BITS-1:0] : t2[DEN_BITS-1:0];
    q_next = {q1[NUM_BITS-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(STEPS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_reg   <= num;
      r_reg   <= '0;
      den_reg <= den;
    end else if (busy) begin
      q_reg <= q_next;
      r_reg <= r_next;
    end
  end

  assign quot      = q_reg;
  assign rem       = r_reg;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### rtl/line_rasterizer.sv
// line rasterizer top: endpoint state, sequencer and output register
// a load word is taken in the idle state and gives no pixel
// a vertical-line step goes from IDLE straight to EMIT and then into the output register
// a sloped step passes through MUL, DIV_START, DIV_WAIT and EMIT; DIV_WAIT lasts until the
// shared divider is done, and the divider retires two quotient bits per cycle
// one step is in flight at a time; a finished pixel may wait in the output register
// synchronous reset clears the sequencer, the output valid and the line state
`timescale 1ns / 1ps

module line_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  lr_cmd_if.sink       cmd,
  lr_pixel_if.source   pixel
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int MW = 2 * COORD_BITS;

  lr_pkg::lr_state_t state, state_next;

  logic [CB-1:0] anchor_x, anchor_y;
  logic [DW-1:0] delta_x, delta_y;
  logic [CB-1:0] walk_position, walk_limit;
  logic [1:0]    vertical_descending;
  logic          line_active;

  logic [CB-1:0] cur_x, cur_y;
  logic          cur_last;
  logic [MW-1:0] prod_mag;
  logic          quot_neg;

  logic          out_valid;
  logic [CB-1:0] out_x, out_y;
  logic          out_last;

  logic          cmd_ready;
  logic          cmd_fire, load_fire, step_fire;
  logic          div_start, emit_fire;

  logic [DW-1:0]        off;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        prod_neg;
  logic [DW-1:0]        dx_neg;
  logic [CB-1:0]        dx_mag;
  logic [MW-1:0]        div_quot;
  logic [CB-1:0]        div_rem;
  lr_pkg::lr_div_stat_t div_stat;
  logic [DW-1:0]        q_ext, y_sum;

  assign cmd_fire  = cmd.valid && cmd_ready;
  assign load_fire = cmd_fire && (cmd.mode == lr_pkg::MODE_LOAD);
  assign step_fire = cmd_fire && (cmd.mode == lr_pkg::MODE_STEP) && line_active;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lr_pkg::ST_IDLE: begin
        if (step_fire) begin
          state_next = vertical_descending[0] ? lr_pkg::ST_EMIT : lr_pkg::ST_MUL;
        end
      end
      lr_pkg::ST_MUL:       state_next = lr_pkg::ST_DIV_START;
      lr_pkg::ST_DIV_START: state_next = lr_pkg::ST_DIV_WAIT;
      lr_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = lr_pkg::ST_EMIT;
        end
      end
      lr_pkg::ST_EMIT: begin
        if (!out_valid || pixel.ready) begin
          state_next = lr_pkg::ST_IDLE;
        end
      end
      default: state_next = lr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready = (state == lr_pkg::ST_IDLE);
    div_start = (state == lr_pkg::ST_DIV_START);
    emit_fire = (state == lr_pkg::ST_EMIT) && (!out_valid || pixel.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // signed product dy * (x - x1), kept as sign and magnitude
  assign off      = {1'b0, walk_position} - {1'b0, anchor_x};
  assign prod     = $signed(off) * $signed(delta_y);
  assign prod_neg = -prod;
  assign dx_neg   = -delta_x;
  assign dx_mag   = delta_x[DW-1] ? dx_neg[CB-1:0] : delta_x[CB-1:0];

  lr_div #(
    .NUM_BITS (MW),
    .DEN_BITS (CB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_mag),
    .den   (dx_mag),
    .quot  (div_quot),
    .rem   (div_rem),
    .stat  (div_stat)
  );

  // floor: a negative quotient with a remainder rounds one further down
  assign q_ext = {1'b0, div_quot[CB-1:0]};
  assign y_sum = quot_neg
               ? ({1'b0, anchor_y} - q_ext - DW'(|div_rem))
               : ({1'b0, anchor_y} + q_ext);

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x            <= '0;
      anchor_y            <= '0;
      delta_x             <= '0;
      delta_y             <= '0;
      walk_position       <= '0;
      walk_limit          <= '0;
      vertical_descending <= '0;
      line_active         <= 1'b0;
    end else if (load_fire) begin
      anchor_x    <= cmd.first_x;
      anchor_y    <= cmd.first_y;
      delta_x     <= {1'b0, cmd.second_x} - {1'b0, cmd.first_x};
      delta_y     <= {1'b0, cmd.second_y} - {1'b0, cmd.first_y};
      line_active <= 1'b1;
      if (cmd.first_x == cmd.second_x) begin
        vertical_descending <= (cmd.first_y > cmd.second_y) ? 2'b11 : 2'b01;
        walk_position       <= cmd.first_y;
        walk_limit          <= cmd.second_y;
      end else begin
        vertical_descending <= 2'b00;
        if (cmd.first_x < cmd.second_x) begin
          walk_position <= cmd.first_x;
          walk_limit    <= cmd.second_x;
        end else begin
          walk_position <= cmd.second_x;
          walk_limit    <= cmd.first_x;
        end
      end
    end else if (emit_fire) begin
      if (cur_last) begin
        line_active <= 1'b0;
      end else if (vertical_descending == 2'b11) begin
        walk_position <= walk_position - 1'b1;
      end else begin
        walk_position <= walk_position + 1'b1;
      end
    end
  end

  // working pixel
  always_ff @(posedge clk) begin
    if (step_fire) begin
      cur_x    <= vertical_descending[0] ? anchor_x : walk_position;
      cur_y    <= walk_position;
      cur_last <= (walk_position == walk_limit);
    end
    if (state == lr_pkg::ST_MUL) begin
      prod_mag <= prod[PW-1] ? prod_neg[MW-1:0] : prod[MW-1:0];
      quot_neg <= prod[PW-1] ^ delta_x[DW-1];
    end
    if ((state == lr_pkg::ST_DIV_WAIT) && div_stat.done) begin
      cur_y <= y_sum[CB-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_x    <= cur_x;
      out_y    <= cur_y;
      out_last <= cur_last;
    end
  end

  assign cmd.ready        = cmd_ready;
  assign pixel.valid      = out_valid;
  assign pixel.pixel_x    = out_x;
  assign pixel.pixel_y    = out_y;
  assign pixel.last_pixel = out_last;

endmodule
